/* hdl/rau_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int RESULT_BITS = 34;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // Datapath commands, issued by the controller states that do work.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_DIV_START,
        CMD_DIV_STEP,
        CMD_GCD_START,
        CMD_GCD_STEP,
        CMD_MUL,
        CMD_SUM
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHK_AB,
        ST_CHK_AB_W,
        ST_CHK_BA,
        ST_CHK_BA_W,
        ST_LG_START,
        ST_LG_STEP,
        ST_LQA_START,
        ST_LQA_W,
        ST_LQB_START,
        ST_LQB_W,
        ST_MUL_AB,
        ST_MUL_BA,
        ST_MUL_LA,
        ST_MUL_LB,
        ST_MUL_LD,
        ST_MUL_NUM,
        ST_MUL_DEN,
        ST_SUM,
        ST_G_START,
        ST_G_STEP,
        ST_RN_START,
        ST_RN_W,
        ST_RD_START,
        ST_RD_W,
        ST_HOLD
    } state_t;

    // Selects which pair of registers the shared divider works on.
    typedef enum logic [2:0] {
        DSEL_DA_DB,
        DSEL_DB_DA,
        DSEL_DA_G,
        DSEL_DB_G,
        DSEL_NUM_G,
        DSEL_DEN_G
    } dsel_t;

    // Selects the operands and the destination of the multiplier.
    typedef enum logic [3:0] {
        MSEL_NONE,
        MSEL_AB,
        MSEL_BA,
        MSEL_LCM_NA,
        MSEL_LCM_NB,
        MSEL_LCM_DEN,
        MSEL_MUL_NUM,
        MSEL_MUL_DEN,
        MSEL_DIV_NUM,
        MSEL_DIV_DEN
    } msel_t;

    // Selects where a finished quotient is stored.
    typedef enum logic [2:0] {
        QSEL_NONE,
        QSEL_KA,
        QSEL_KB,
        QSEL_NUM,
        QSEL_DEN
    } qsel_t;

    typedef struct packed {
        cmd_t  cmd;
        dsel_t dsel;
        msel_t msel;
        qsel_t qsel;
        logic  gsel_num;   // gcd on num/den when set, on da/db otherwise
    } ctrl_t;

    typedef struct packed {
        logic div_done;
        logic rem_zero;
        logic gcd_done;
        logic error;
        logic op_addsub;
        logic op_div;
    } stat_t;

endpackage
`default_nettype wire

/* hdl/rau_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Operand registers, a shared restoring divider, a shared binary GCD unit
// and one multiplier, driven step by step by the controller.
// ----------------------------------------------------------------------------
module rau_datapath
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire logic [1:0]              operation,
    input  wire logic [OPERAND_BITS-1:0] numerator_a,
    input  wire logic [OPERAND_BITS-1:0] denominator_a,
    input  wire logic [OPERAND_BITS-1:0] numerator_b,
    input  wire logic [OPERAND_BITS-1:0] denominator_b,
    input  wire ctrl_t                   ctrl,
    output stat_t                        stat,
    output logic [RESULT_BITS-1:0]       res_num,
    output logic [RESULT_BITS-1:0]       res_den,
    output logic                         res_err
);

    // Magnitudes up to 2*OB+1 bits cover the LCM path's sums; the working
    // width never drops below the result width.
    localparam int MW = (2 * OPERAND_BITS + 2 > RESULT_BITS)
                        ? 2 * OPERAND_BITS + 2 : RESULT_BITS;
    localparam int CW = $clog2(MW + 1);

    logic [MW-1:0] na_reg, nb_reg, da_reg, db_reg;
    logic          nan_reg, nbn_reg, dan_reg, dbn_reg;
    logic [MW-1:0] num_reg, den_reg;
    logic          numn_reg, denn_reg;
    logic [MW-1:0] ka_reg, kb_reg, g_reg;
    logic [1:0]    op_reg;
    logic          err_reg;

    // Divider
    logic [MW-1:0] dq_reg, dr_reg, dd_reg;
    logic [CW-1:0] dcnt_reg;
    logic          dbusy_reg;
    // Binary GCD
    logic [MW-1:0] ga_reg, gb_reg;
    logic [CW-1:0] gsh_reg;
    logic          gbusy_reg;

    logic [OPERAND_BITS-1:0] zo;
    logic [MW-1:0] num_s, den_s, trial;
    logic [MW:0]   rsh;

    function automatic logic [MW-1:0] mag(input logic [OPERAND_BITS-1:0] v);
        logic [OPERAND_BITS-1:0] t;
        t = v[OPERAND_BITS-1] ? (~v + 1'b1) : v;
        if (v[OPERAND_BITS-1] && t == '0)
            mag = {{(MW-OPERAND_BITS){1'b0}}, 1'b1, {(OPERAND_BITS-1){1'b0}}};
        else
            mag = {{(MW-OPERAND_BITS){1'b0}}, t};
    endfunction

    assign zo = '0;

    always_comb
    begin
        unique case (ctrl.dsel)
            DSEL_DA_DB: begin num_s = da_reg;  den_s = db_reg; end
            DSEL_DB_DA: begin num_s = db_reg;  den_s = da_reg; end
            DSEL_DA_G:  begin num_s = da_reg;  den_s = g_reg;  end
            DSEL_DB_G:  begin num_s = db_reg;  den_s = g_reg;  end
            DSEL_NUM_G: begin num_s = num_reg; den_s = g_reg;  end
            DSEL_DEN_G: begin num_s = den_reg; den_s = g_reg;  end
            default:    begin num_s = da_reg;  den_s = db_reg; end
        endcase
    end

    // One restoring step: shift the next dividend bit into the remainder.
    assign rsh   = {dr_reg, dq_reg[MW-1]};
    assign trial = rsh[MW-1:0] - dd_reg;

    // Every multiplier operand is an input magnitude or a quotient of two,
    // so OPERAND_BITS on each side is enough.
    logic [OPERAND_BITS-1:0]   ma, mb;
    logic [2*OPERAND_BITS-1:0] prod;
    logic [MW-1:0]             prod_w;
    always_comb
    begin
        unique case (ctrl.msel)
            MSEL_AB:      begin ma = nb_reg[OPERAND_BITS-1:0]; mb = ka_reg[OPERAND_BITS-1:0]; end
            MSEL_BA:      begin ma = na_reg[OPERAND_BITS-1:0]; mb = ka_reg[OPERAND_BITS-1:0]; end
            MSEL_LCM_NA:  begin ma = na_reg[OPERAND_BITS-1:0]; mb = ka_reg[OPERAND_BITS-1:0]; end
            MSEL_LCM_NB:  begin ma = nb_reg[OPERAND_BITS-1:0]; mb = kb_reg[OPERAND_BITS-1:0]; end
            MSEL_LCM_DEN: begin ma = kb_reg[OPERAND_BITS-1:0]; mb = db_reg[OPERAND_BITS-1:0]; end
            MSEL_MUL_NUM: begin ma = na_reg[OPERAND_BITS-1:0]; mb = nb_reg[OPERAND_BITS-1:0]; end
            MSEL_MUL_DEN: begin ma = da_reg[OPERAND_BITS-1:0]; mb = db_reg[OPERAND_BITS-1:0]; end
            MSEL_DIV_NUM: begin ma = na_reg[OPERAND_BITS-1:0]; mb = db_reg[OPERAND_BITS-1:0]; end
            MSEL_DIV_DEN: begin ma = da_reg[OPERAND_BITS-1:0]; mb = nb_reg[OPERAND_BITS-1:0]; end
            default:      begin ma = na_reg[OPERAND_BITS-1:0]; mb = nb_reg[OPERAND_BITS-1:0]; end
        endcase
    end
    assign prod   = ma * mb;
    assign prod_w = {{(MW-2*OPERAND_BITS){1'b0}}, prod};

    logic [MW-1:0] sum_mag;
    logic          sum_neg;
    always_comb
    begin
        if (nan_reg == nbn_reg) begin
            sum_mag = na_reg + nb_reg;
            sum_neg = nan_reg;
        end else if (na_reg >= nb_reg) begin
            sum_mag = na_reg - nb_reg;
            sum_neg = nan_reg;
        end else begin
            sum_mag = nb_reg - na_reg;
            sum_neg = nbn_reg;
        end
        if (sum_mag == '0)
            sum_neg = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dbusy_reg <= 1'b0;
            gbusy_reg <= 1'b0;
            err_reg   <= 1'b0;
        end else begin
            if (load) begin
                op_reg  <= operation;
                na_reg  <= mag(numerator_a);
                nan_reg <= numerator_a[OPERAND_BITS-1];
                da_reg  <= mag(denominator_a);
                dan_reg <= denominator_a[OPERAND_BITS-1];
                db_reg  <= mag(denominator_b);
                dbn_reg <= denominator_b[OPERAND_BITS-1];
                nb_reg  <= mag(numerator_b);
                nbn_reg <= (operation == OP_SUB && numerator_b != zo)
                    ? ~numerator_b[OPERAND_BITS-1] : numerator_b[OPERAND_BITS-1];
                err_reg <= (denominator_a == zo) || (denominator_b == zo)
                    || (operation == OP_DIV && numerator_b == zo);
            end
            unique case (ctrl.cmd)
                CMD_DIV_START: begin
                    dq_reg    <= num_s;
                    dd_reg    <= den_s;
                    dr_reg    <= '0;
                    dcnt_reg  <= CW'(MW);
                    dbusy_reg <= 1'b1;
                end
                CMD_DIV_STEP: begin
                    if (dbusy_reg) begin
                        if (!rsh[MW] && rsh[MW-1:0] < dd_reg) begin
                            dr_reg <= rsh[MW-1:0];
                            dq_reg <= {dq_reg[MW-2:0], 1'b0};
                        end else begin
                            dr_reg <= trial;
                            dq_reg <= {dq_reg[MW-2:0], 1'b1};
                        end
                        dcnt_reg <= dcnt_reg - 1'b1;
                        if (dcnt_reg == CW'(1))
                            dbusy_reg <= 1'b0;
                    end else begin
                        // Divider finished: store its quotient where the
                        // controller says.
                        unique case (ctrl.qsel)
                            QSEL_KA:  ka_reg  <= dq_reg;
                            QSEL_KB:  kb_reg  <= dq_reg;
                            QSEL_NUM: num_reg <= dq_reg;
                            QSEL_DEN: den_reg <= dq_reg;
                            default:  ;
                        endcase
                    end
                end
                CMD_GCD_START: begin
                    ga_reg    <= ctrl.gsel_num ? num_reg : da_reg;
                    gb_reg    <= ctrl.gsel_num ? den_reg : db_reg;
                    gsh_reg   <= '0;
                    gbusy_reg <= 1'b1;
                end
                CMD_GCD_STEP: begin
                    // Binary GCD: one halving or one odd-odd subtract a cycle,
                    // common factors of two counted in gsh_reg.
                    if (gbusy_reg) begin
                        if (ga_reg == '0) begin
                            g_reg     <= gb_reg << gsh_reg;
                            gbusy_reg <= 1'b0;
                        end else if (gb_reg == '0) begin
                            g_reg     <= ga_reg << gsh_reg;
                            gbusy_reg <= 1'b0;
                        end else if (!ga_reg[0] && !gb_reg[0]) begin
                            ga_reg  <= ga_reg >> 1;
                            gb_reg  <= gb_reg >> 1;
                            gsh_reg <= gsh_reg + 1'b1;
                        end else if (!ga_reg[0]) begin
                            ga_reg <= ga_reg >> 1;
                        end else if (!gb_reg[0]) begin
                            gb_reg <= gb_reg >> 1;
                        end else if (ga_reg >= gb_reg) begin
                            ga_reg <= ga_reg - gb_reg;
                        end else begin
                            gb_reg <= gb_reg - ga_reg;
                        end
                    end
                end
                CMD_MUL: begin
                    unique case (ctrl.msel)
                        MSEL_AB: begin
                            nb_reg  <= prod_w;
                            nbn_reg <= (prod != '0) && (nbn_reg != (dan_reg != dbn_reg));
                            den_reg <= da_reg; denn_reg <= dan_reg;
                        end
                        MSEL_BA: begin
                            na_reg  <= prod_w;
                            nan_reg <= (prod != '0) && (nan_reg != (dan_reg != dbn_reg));
                            den_reg <= db_reg; denn_reg <= dbn_reg;
                        end
                        MSEL_LCM_NA: begin
                            na_reg  <= prod_w;
                            nan_reg <= (prod != '0) && (nan_reg != dan_reg);
                        end
                        MSEL_LCM_NB: begin
                            nb_reg  <= prod_w;
                            nbn_reg <= (prod != '0) && (nbn_reg != dbn_reg);
                        end
                        MSEL_LCM_DEN: begin
                            den_reg  <= prod_w;
                            denn_reg <= 1'b0;
                        end
                        MSEL_MUL_NUM: begin
                            num_reg  <= prod_w;
                            numn_reg <= (prod != '0) && (nan_reg != nbn_reg);
                        end
                        MSEL_MUL_DEN: begin
                            den_reg  <= prod_w;
                            denn_reg <= (prod != '0) && (dan_reg != dbn_reg);
                        end
                        MSEL_DIV_NUM: begin
                            num_reg  <= prod_w;
                            numn_reg <= (prod != '0) && (nan_reg != dbn_reg);
                        end
                        MSEL_DIV_DEN: begin
                            den_reg  <= prod_w;
                            denn_reg <= (prod != '0) && (dan_reg != nbn_reg);
                        end
                        default: ;
                    endcase
                end
                CMD_SUM: begin
                    num_reg  <= sum_mag;
                    numn_reg <= sum_neg;
                end
                default: ;
            endcase
        end
    end

    assign stat = '{div_done:  !dbusy_reg,
                    rem_zero:  (dr_reg == '0),
                    gcd_done:  !gbusy_reg,
                    error:     err_reg,
                    op_addsub: (op_reg == OP_ADD) || (op_reg == OP_SUB),
                    op_div:    (op_reg == OP_DIV)};

    logic [MW-1:0] nres, dres;
    assign nres = numn_reg ? (~num_reg + 1'b1) : num_reg;
    assign dres = denn_reg ? (~den_reg + 1'b1) : den_reg;
    assign res_num = err_reg ? '0 : nres[RESULT_BITS-1:0];
    assign res_den = err_reg ? '0 : dres[RESULT_BITS-1:0];
    assign res_err = err_reg;

endmodule
`default_nettype wire

/* hdl/rau_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences loading, divisibility checks, LCM, scaling, summing, the
// products for multiply and divide, reduction and the output transfer.
// ----------------------------------------------------------------------------
module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic       load,
    output ctrl_t      ctrl,
    input  wire stat_t stat
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_LOAD;
            ST_LOAD:      state_next = stat.error ? ST_HOLD
                              : (stat.op_addsub ? ST_CHK_AB : ST_MUL_NUM);
            ST_CHK_AB:    state_next = ST_CHK_AB_W;
            ST_CHK_AB_W:  if (stat.div_done) state_next = stat.rem_zero ? ST_MUL_AB : ST_CHK_BA;
            ST_CHK_BA:    state_next = ST_CHK_BA_W;
            ST_CHK_BA_W:  if (stat.div_done) state_next = stat.rem_zero ? ST_MUL_BA : ST_LG_START;
            ST_LG_START:  state_next = ST_LG_STEP;
            ST_LG_STEP:   if (stat.gcd_done) state_next = ST_LQA_START;
            ST_LQA_START: state_next = ST_LQA_W;
            ST_LQA_W:     if (stat.div_done) state_next = ST_LQB_START;
            ST_LQB_START: state_next = ST_LQB_W;
            ST_LQB_W:     if (stat.div_done) state_next = ST_MUL_LA;
            ST_MUL_AB:    state_next = ST_SUM;
            ST_MUL_BA:    state_next = ST_SUM;
            ST_MUL_LA:    state_next = ST_MUL_LB;
            ST_MUL_LB:    state_next = ST_MUL_LD;
            ST_MUL_LD:    state_next = ST_SUM;
            ST_MUL_NUM:   state_next = ST_MUL_DEN;
            ST_MUL_DEN:   state_next = ST_G_START;
            ST_SUM:       state_next = ST_G_START;
            ST_G_START:   state_next = ST_G_STEP;
            ST_G_STEP:    if (stat.gcd_done) state_next = ST_RN_START;
            ST_RN_START:  state_next = ST_RN_W;
            ST_RN_W:      if (stat.div_done) state_next = ST_RD_START;
            ST_RD_START:  state_next = ST_RD_W;
            ST_RD_W:      if (stat.div_done) state_next = ST_HOLD;
            ST_HOLD:      if (!out_stall) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '{cmd: CMD_NONE, dsel: DSEL_DA_DB, msel: MSEL_NONE,
                      qsel: QSEL_NONE, gsel_num: 1'b0};
        load      = 1'b0;
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_HOLD);
        unique case (state_reg)
            ST_IDLE:      load = in_valid;
            ST_CHK_AB:    begin ctrl.cmd = CMD_DIV_START; ctrl.dsel = DSEL_DA_DB; end
            ST_CHK_AB_W:  begin ctrl.cmd = CMD_DIV_STEP; ctrl.qsel = QSEL_KA; end
            ST_CHK_BA:    begin ctrl.cmd = CMD_DIV_START; ctrl.dsel = DSEL_DB_DA; end
            ST_CHK_BA_W:  begin ctrl.cmd = CMD_DIV_STEP; ctrl.qsel = QSEL_KA; end
            ST_LG_START:  ctrl.cmd = CMD_GCD_START;
            ST_LG_STEP:   ctrl.cmd = CMD_GCD_STEP;
            // The LCM cofactors: kb = da/g and ka = db/g.
            ST_LQA_START: begin ctrl.cmd = CMD_DIV_START; ctrl.dsel = DSEL_DA_G; end
            ST_LQA_W:     begin ctrl.cmd = CMD_DIV_STEP; ctrl.qsel = QSEL_KB; end
            ST_LQB_START: begin ctrl.cmd = CMD_DIV_START; ctrl.dsel = DSEL_DB_G; end
            ST_LQB_W:     begin ctrl.cmd = CMD_DIV_STEP; ctrl.qsel = QSEL_KA; end
            ST_MUL_AB:    begin ctrl.cmd = CMD_MUL; ctrl.msel = MSEL_AB; end
            ST_MUL_BA:    begin ctrl.cmd = CMD_MUL; ctrl.msel = MSEL_BA; end
            ST_MUL_LA:    begin ctrl.cmd = CMD_MUL; ctrl.msel = MSEL_LCM_NA; end
            ST_MUL_LB:    begin ctrl.cmd = CMD_MUL; ctrl.msel = MSEL_LCM_NB; end
            ST_MUL_LD:    begin ctrl.cmd = CMD_MUL; ctrl.msel = MSEL_LCM_DEN; end
            ST_MUL_NUM:   begin
                ctrl.cmd  = CMD_MUL;
                ctrl.msel = stat.op_div ? MSEL_DIV_NUM : MSEL_MUL_NUM;
            end
            ST_MUL_DEN:   begin
                ctrl.cmd  = CMD_MUL;
                ctrl.msel = stat.op_div ? MSEL_DIV_DEN : MSEL_MUL_DEN;
            end
            ST_SUM:       ctrl.cmd = CMD_SUM;
            ST_G_START:   begin ctrl.cmd = CMD_GCD_START; ctrl.gsel_num = 1'b1; end
            ST_G_STEP:    ctrl.cmd = CMD_GCD_STEP;
            ST_RN_START:  begin ctrl.cmd = CMD_DIV_START; ctrl.dsel = DSEL_NUM_G; end
            ST_RN_W:      begin ctrl.cmd = CMD_DIV_STEP; ctrl.qsel = QSEL_NUM; end
            ST_RD_START:  begin ctrl.cmd = CMD_DIV_START; ctrl.dsel = DSEL_DEN_G; end
            ST_RD_W:      begin ctrl.cmd = CMD_DIV_STEP; ctrl.qsel = QSEL_DEN; end
            default: ;
        endcase
    end

    ap_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("output transfer repeated");
    ap_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result waits");
    ap_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !in_stall)
        else $error("load outside idle");

endmodule
`default_nettype wire

/* hdl/rational_arithmetic_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result by the greatest common divisor of its magnitudes.
// ----------------------------------------------------------------------------
// One item is worked at a time: the input stalls from its transfer until the
// result has been taken, and the next input is accepted in the cycle after the
// output transfer. The operands are loaded as magnitudes with signs, then a
// fixed sequence runs on a shared restoring divider, a shared binary GCD
// unit and one OPERAND_BITS by OPERAND_BITS multiplier. Each divider pass
// steps through every bit of the working width, which is at least 34 bits.
// Multiply and divide use two passes; add and subtract use up to six: two
// divisibility checks, two LCM cofactors and the two final reductions.
// Each GCD takes a start step, then halving or subtract steps until one
// operand is zero, and a finishing step. A zero denominator, or a division
// by a zero fraction, skips all of this and the error result is offered
// from the hold state, reached by way of the load state. The result is held
// unchanged until its transfer completes.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [1:0]              operation,
    input  wire logic [OPERAND_BITS-1:0] numerator_a,
    input  wire logic [OPERAND_BITS-1:0] denominator_a,
    input  wire logic [OPERAND_BITS-1:0] numerator_b,
    input  wire logic [OPERAND_BITS-1:0] denominator_b,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [RESULT_BITS-1:0]       result_numerator,
    output logic [RESULT_BITS-1:0]       result_denominator,
    output logic                         zero_denominator_error
);

    ctrl_t      ctrl;
    stat_t      stat;
    logic       load;

    // The controller sequences every step; the datapath only follows.
    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .load      (load),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    rau_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .operation     (operation),
        .numerator_a   (numerator_a),
        .denominator_a (denominator_a),
        .numerator_b   (numerator_b),
        .denominator_b (denominator_b),
        .ctrl          (ctrl),
        .stat          (stat),
        .res_num       (result_numerator),
        .res_den       (result_denominator),
        .res_err       (zero_denominator_error)
    );

endmodule
`default_nettype wire

/* verif/rational_arithmetic_unit_tb.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction pairs with every operation through the valid/stall ports,
// predicts each reduced fraction with a behavioral model of the unit where
// a row does not spell it out, and compares every result transfer field by
// field against the oldest prediction. Directed corner rows come first, then
// randomized bursty traffic and a receiver that stalls on its own pattern.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int W           = 16;
    localparam int NUM_RANDOM  = 530;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PAUSE_ITEM  = 350;

    // Signed-magnitude working value, as wide as any intermediate needs.
    typedef struct {
        bit              neg;
        longint unsigned mag;
    } signmag_t;

    // One fraction pair and, for rows that spell it out, the result it gives.
    typedef struct {
        op_t            op;
        logic [W-1:0]   na;
        logic [W-1:0]   da;
        logic [W-1:0]   nb;
        logic [W-1:0]   db;
        bit             spelled;
        logic [RESULT_BITS-1:0] rn;
        logic [RESULT_BITS-1:0] rd;
        logic           err;
    } fraction_pair_t;

    typedef struct {
        logic [RESULT_BITS-1:0] rn;
        logic [RESULT_BITS-1:0] rd;
        logic                   err;
    } reduced_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             operation;
    logic [W-1:0]           numerator_a;
    logic [W-1:0]           denominator_a;
    logic [W-1:0]           numerator_b;
    logic [W-1:0]           denominator_b;
    logic                   out_valid;
    logic                   out_stall;
    logic [RESULT_BITS-1:0] result_numerator;
    logic [RESULT_BITS-1:0] result_denominator;
    logic                   zero_denominator_error;

    fraction_pair_t pair_list[$];
    reduced_t       pending_results[$];
    int             mismatches;
    int             results_checked;
    int             error_results;
    int             op_count[4];
    int             cycle_count;
    bit             long_hold_done;

    rational_arithmetic_unit #(.OPERAND_BITS(W)) uut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .operation              (operation),
        .numerator_a            (numerator_a),
        .denominator_a          (denominator_a),
        .numerator_b            (numerator_b),
        .denominator_b          (denominator_b),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .result_numerator       (result_numerator),
        .result_denominator     (result_denominator),
        .zero_denominator_error (zero_denominator_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral model of the unit.
    // ------------------------------------------------------------------------
    function automatic signmag_t to_signmag(logic [W-1:0] raw);
        signmag_t v;
        v.neg = raw[W-1];
        v.mag = v.neg ? ((longint'(1) << W) - raw) : longint'(raw);
        return v;
    endfunction

    // A zero product is never negative.
    function automatic signmag_t times(signmag_t x, signmag_t y);
        signmag_t r;
        r.mag = x.mag * y.mag;
        r.neg = (r.mag != 0) && (x.neg != y.neg);
        return r;
    endfunction

    function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [RESULT_BITS-1:0] to_field(signmag_t v);
        longint unsigned m;
        m = v.neg ? (64'd0 - v.mag) : v.mag;
        return m[RESULT_BITS-1:0];
    endfunction

    function automatic reduced_t reduce_fraction(fraction_pair_t p);
        signmag_t        na;
        signmag_t        da;
        signmag_t        nb;
        signmag_t        db;
        signmag_t        num;
        signmag_t        den;
        signmag_t        ka;
        signmag_t        kb;
        longint unsigned lcm;
        longint unsigned g;
        reduced_t        r;
        na = to_signmag(p.na);
        da = to_signmag(p.da);
        nb = to_signmag(p.nb);
        db = to_signmag(p.db);
        r.rn  = '0;
        r.rd  = '0;
        r.err = 1'b1;
        // A zero denominator at the input, or division by a zero fraction.
        if (da.mag == 0 || db.mag == 0 || (p.op == OP_DIV && nb.mag == 0))
            return r;
        if (p.op == OP_ADD || p.op == OP_SUB)
        begin
            if (p.op == OP_SUB && nb.mag != 0)
                nb.neg = !nb.neg;
            if (da.mag % db.mag == 0)
            begin
                ka.mag = da.mag / db.mag;
                ka.neg = da.neg != db.neg;
                nb  = times(nb, ka);
                den = da;
            end
            else if (db.mag % da.mag == 0)
            begin
                ka.mag = db.mag / da.mag;
                ka.neg = da.neg != db.neg;
                na  = times(na, ka);
                den = db;
            end
            else
            begin
                lcm    = (da.mag / euclid(da.mag, db.mag)) * db.mag;
                ka.mag = lcm / da.mag;
                ka.neg = da.neg;
                kb.mag = lcm / db.mag;
                kb.neg = db.neg;
                na      = times(na, ka);
                nb      = times(nb, kb);
                den.mag = lcm;
                den.neg = 1'b0;
            end
            if (na.neg == nb.neg)
            begin
                num.mag = na.mag + nb.mag;
                num.neg = na.neg;
            end
            else if (na.mag >= nb.mag)
            begin
                num.mag = na.mag - nb.mag;
                num.neg = na.neg;
            end
            else
            begin
                num.mag = nb.mag - na.mag;
                num.neg = nb.neg;
            end
            if (num.mag == 0)
                num.neg = 1'b0;
        end
        else if (p.op == OP_MUL)
        begin
            num = times(na, nb);
            den = times(da, db);
        end
        else
        begin
            num = times(na, db);
            den = times(da, nb);
        end
        g = euclid(num.mag, den.mag);
        if (g != 0)
        begin
            num.mag = num.mag / g;
            den.mag = den.mag / g;
        end
        r.rn  = to_field(num);
        r.rd  = to_field(den);
        r.err = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------------
    task automatic add_pair(op_t op, int na, int da, int nb, int db, bit spelled,
                            longint rn, longint rd, logic err);
        fraction_pair_t p;
        p.op      = op;
        p.na      = na[W-1:0];
        p.da      = da[W-1:0];
        p.nb      = nb[W-1:0];
        p.db      = db[W-1:0];
        p.spelled = spelled;
        p.rn      = rn[RESULT_BITS-1:0];
        p.rd      = rd[RESULT_BITS-1:0];
        p.err     = err;
        pair_list.push_back(p);
    endtask

    // Mixes full-range values with small ones, extremes and powers of two so
    // that the multiple-of cases and real reductions come up often.
    function automatic int random_operand();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
            3, 4, 5: v = int'($urandom_range(0, 40)) - 20;
            6:       v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
            7:       v = (1 << $urandom_range(0, 14)) * (($urandom_range(0, 1) == 1) ? -1 : 1);
            default: v = (int'($urandom_range(1, 30)) * int'($urandom_range(1, 1000)))
                         * (($urandom_range(0, 1) == 1) ? -1 : 1);
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: walks the stimulus list in bursts with random gaps.
    // ------------------------------------------------------------------------
    initial
    begin
        int             idx;
        int             burst_left;
        int             gap;
        fraction_pair_t p;
        reduced_t       want;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = '0;
        numerator_a   = '0;
        denominator_a = '0;
        numerator_b   = '0;
        denominator_b = '0;
        mismatches      = 0;
        results_checked = 0;
        error_results   = 0;
        op_count        = '{0, 0, 0, 0};

        // Directed rows. Results are spelled out only where they are obvious.
        add_pair(OP_ADD, 1, 0, 1, 1, 1, 0, 0, 1);
        add_pair(OP_MUL, 3, 4, 5, 0, 1, 0, 0, 1);
        add_pair(OP_DIV, 5, 3, 0, 7, 1, 0, 0, 1);
        add_pair(OP_SUB, -32768, 0, 32767, 0, 1, 0, 0, 1);
        add_pair(OP_MUL, 0, -3, 5, 7, 1, 0, -1, 0);
        add_pair(OP_MUL, 0, 3, 5, 7, 1, 0, 1, 0);
        add_pair(OP_ADD, 1, -4, 1, 4, 1, 0, -1, 0);
        add_pair(OP_MUL, -32768, 1, -32768, 1, 1, 64'd1 << 30, 1, 0);
        add_pair(OP_DIV, -32768, 1, 1, -32768, 1, 64'd1 << 30, 1, 0);
        add_pair(OP_ADD, 1, 32767, 1, -32768, 0, 0, 0, 0);
        add_pair(OP_SUB, 32767, -32768, -32768, 32767, 0, 0, 0, 0);
        add_pair(OP_MUL, 32767, -32768, 32767, -32768, 0, 0, 0, 0);
        add_pair(OP_DIV, -32768, 32767, 32767, -32768, 0, 0, 0, 0);
        add_pair(OP_ADD, 1, 6, 1, 3, 0, 0, 0, 0);
        add_pair(OP_ADD, 1, 3, 1, 6, 0, 0, 0, 0);
        add_pair(OP_SUB, 5, 4, -7, 6, 0, 0, 0, 0);
        add_pair(OP_SUB, 3, 9, 3, -9, 0, 0, 0, 0);
        add_pair(OP_DIV, 6, 35, -10, 21, 0, 0, 0, 0);
        add_pair(OP_ADD, -1, -1, -1, -1, 0, 0, 0, 0);
        add_pair(OP_SUB, 0, -7, 0, 7, 0, 0, 0, 0);
        for (int i = 0; i < NUM_RANDOM; i++)
            add_pair(op_t'($urandom_range(0, 3)), random_operand(), random_operand(),
                     random_operand(), random_operand(), 0, 0, 0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        idx        = 0;
        while (idx < pair_list.size())
        begin
            if (idx == PAUSE_ITEM)
            begin
                // Let the unit drain completely before going on.
                in_valid <= 1'b0;
                @(negedge clk);
                while (pending_results.size() != 0)
                    @(negedge clk);
                @(posedge clk);
            end
            else if (burst_left == 0)
            begin
                gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
                burst_left = $urandom_range(1, 30);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            p = pair_list[idx];
            in_valid      <= 1'b1;
            operation     <= p.op;
            numerator_a   <= p.na;
            denominator_a <= p.da;
            numerator_b   <= p.nb;
            denominator_b <= p.db;
            // The transfer happens at the edge after a clean negedge sample.
            @(negedge clk);
            while (in_stall)
                @(negedge clk);
            @(posedge clk);
            if (p.spelled)
            begin
                want.rn  = p.rn;
                want.rd  = p.rd;
                want.err = p.err;
            end
            else
                want = reduce_fraction(p);
            pending_results.push_back(want);
            op_count[p.op]++;
            burst_left--;
            idx++;
        end
        in_valid <= 1'b0;

        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        // Watch for any stray result after the last one.
        repeat (40) @(posedge clk);

        $display("Checked %0d results (%0d error results) from add %0d, sub %0d, mul %0d, div %0d.",
                 results_checked, error_results, op_count[OP_ADD], op_count[OP_SUB],
                 op_count[OP_MUL], op_count[OP_DIV]);
        $display("Mismatches: %0d, with bursty input, a long output hold-off and a full drain.",
                 mismatches);
        if (mismatches == 0)
            $display("rational_arithmetic_unit verification clean");
        else
            $display("rational_arithmetic_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stalls in changing patterns, with one long hold-off once
    // enough results have come so that the input side backs up.
    // ------------------------------------------------------------------------
    initial
    begin
        int mode;
        int hold_left;
        out_stall      = 1'b0;
        long_hold_done = 1'b0;
        mode           = 0;
        hold_left      = 0;
        forever
        begin
            @(posedge clk);
            if (cycle_count % 200 == 0)
                mode = $urandom_range(0, 3);
            if (!long_hold_done && results_checked >= 100)
            begin
                long_hold_done = 1'b1;
                hold_left      = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 1) == 1);
                    2:       out_stall <= ($urandom_range(0, 9) != 0);
                    default: out_stall <= (cycle_count % 7 < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: samples at the falling edge, where outputs are settled.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        reduced_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: %h / %h err %b",
                             result_numerator, result_denominator, zero_denominator_error);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (zero_denominator_error)
                    error_results++;
                if (result_numerator !== want.rn || result_denominator !== want.rd
                    || zero_denominator_error !== want.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d mismatch: expected %h / %h err %b, got %h / %h err %b",
                                 results_checked, want.rn, want.rd, want.err,
                                 result_numerator, result_denominator, zero_denominator_error);
                end
            end
        end
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles with %0d results outstanding.",
                         cycle_count, pending_results.size());
                $display("rational_arithmetic_unit verification failed");
                $finish;
            end
        end
    end

endmodule
